@@ rtl/assert_macros.svh @@
// Concurrent assertion helpers for the date span block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/dsw_pkg.sv @@
package dsw_pkg;

   localparam int DAY_W   = 6;
   localparam int MON_W   = 4;
   localparam int YEAR_W  = 14;
   localparam int SPAN_W  = 22;
   localparam int WDAY_W  = 3;
   localparam int DNUM_W  = 23;
   localparam int ZSUM_W  = 11;
   localparam int Q100_W  = 8;
   localparam int DIVD_W  = 14;
   localparam int DIVS_W  = 7;
   localparam int RECIP_W = 13;
   localparam int PROD_W  = 27;
   localparam int SHIFT_W = 5;

   localparam int MAX_YEAR_DEF  = 9999;
   localparam int DAYS_PER_YEAR = 365;

   typedef logic [DAY_W-1:0]   day_type;
   typedef logic [MON_W-1:0]   mon_type;
   typedef logic [YEAR_W-1:0]  year_type;
   typedef logic [SPAN_W-1:0]  span_type;
   typedef logic [WDAY_W-1:0]  wday_type;
   typedef logic [DNUM_W-1:0]  dnum_type;
   typedef logic [ZSUM_W-1:0]  zsum_type;
   typedef logic [Q100_W-1:0]  q100_type;
   typedef logic [DIVD_W-1:0]  divd_type;
   typedef logic [DIVS_W-1:0]  divs_type;
   typedef logic [RECIP_W-1:0] recip_type;
   typedef logic [PROD_W-1:0]  prod_type;
   typedef logic [SHIFT_W-1:0] shift_type;
   typedef logic [8:0]         mstart_type;

   localparam mon_type MON_JAN = mon_type'(1);
   localparam mon_type MON_FEB = mon_type'(2);
   localparam mon_type MON_MAR = mon_type'(3);
   localparam mon_type MON_DEC = mon_type'(12);

   localparam day_type   FEB_LEAP_LEN = day_type'(29);
   localparam divs_type  R100_LAST    = divs_type'(99);
   localparam divs_type  DIV_BY_100   = divs_type'(100);
   localparam divs_type  DIV_BY_7     = divs_type'(7);
   localparam dnum_type  SPAN_MAX     = dnum_type'((1 << SPAN_W) - 1);

   // ceil(2^shift / divisor), exact over the dividends that reach each divisor
   localparam recip_type RECIP_100    = recip_type'(5243);
   localparam shift_type SHIFT_100    = shift_type'(19);
   localparam recip_type RECIP_7      = recip_type'(2341);
   localparam shift_type SHIFT_7      = shift_type'(14);

   typedef struct packed {
      day_type  first_day;
      mon_type  first_month;
      year_type first_year;
      day_type  second_day;
      mon_type  second_month;
      year_type second_year;
   } req_data_type;

   typedef struct packed {
      logic     dates_valid;
      span_type day_span;
      wday_type first_weekday;
      wday_type second_weekday;
   } rsp_data_type;

   typedef struct packed {
      logic     start;
      divd_type dividend;
      divs_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      divd_type quot;
      divs_type rem;
   } div_rsp_type;

   typedef struct packed {
      logic     ok;
      zsum_type zsum;
      year_type p;
      dnum_type prod;
      dnum_type daynum;
   } date_info_type;

   function automatic day_type month_len(input mon_type m);
      day_type len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = day_type'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                    len = day_type'(30);
         4'd2:                                       len = day_type'(28);
         default:                                    len = day_type'(0);
      endcase
      return len;
   endfunction

   function automatic mstart_type month_start(input mon_type m);
      mstart_type s;
      unique case (m)
         4'd1:    s = mstart_type'(0);
         4'd2:    s = mstart_type'(31);
         4'd3:    s = mstart_type'(59);
         4'd4:    s = mstart_type'(90);
         4'd5:    s = mstart_type'(120);
         4'd6:    s = mstart_type'(151);
         4'd7:    s = mstart_type'(181);
         4'd8:    s = mstart_type'(212);
         4'd9:    s = mstart_type'(243);
         4'd10:   s = mstart_type'(273);
         4'd11:   s = mstart_type'(304);
         4'd12:   s = mstart_type'(334);
         default: s = mstart_type'(0);
      endcase
      return s;
   endfunction

   // 13 * (M + 1) / 5, January and February counted as months 13 and 14
   function automatic day_type zeller_term(input mon_type m);
      day_type t;
      unique case (m)
         4'd1:    t = day_type'(36);
         4'd2:    t = day_type'(39);
         4'd3:    t = day_type'(10);
         4'd4:    t = day_type'(13);
         4'd5:    t = day_type'(15);
         4'd6:    t = day_type'(18);
         4'd7:    t = day_type'(20);
         4'd8:    t = day_type'(23);
         4'd9:    t = day_type'(26);
         4'd10:   t = day_type'(28);
         4'd11:   t = day_type'(31);
         4'd12:   t = day_type'(33);
         default: t = day_type'(0);
      endcase
      return t;
   endfunction

endpackage

@@ rtl/dsw_if.sv @@
interface dsw_req_if;
   logic                 valid;
   logic                 ready;
   dsw_pkg::req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface dsw_rsp_if;
   logic                 valid;
   logic                 ready;
   dsw_pkg::rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/dsw_divu.sv @@
`include "assert_macros.svh"

module dsw_divu (
   input  logic                 clock,
   input  logic                 reset,
   input  dsw_pkg::div_req_type div_req,
   output dsw_pkg::div_rsp_type div_rsp
);

   localparam logic [1:0] P_IDLE  = 2'd0;
   localparam logic [1:0] P_RECIP = 2'd1;
   localparam logic [1:0] P_BACK  = 2'd2;

   logic [1:0]          phase_ff, phase_in;
   logic                done_ff, done_in;
   dsw_pkg::divd_type   num_ff, num_in;
   dsw_pkg::divs_type   divisor_ff, divisor_in;
   dsw_pkg::divd_type   quot_ff, quot_in;
   dsw_pkg::divs_type   rem_ff, rem_in;

   dsw_pkg::recip_type  recip;
   dsw_pkg::shift_type  shift;
   dsw_pkg::divd_type   mul_a;
   dsw_pkg::recip_type  mul_b;
   dsw_pkg::prod_type   mul_p;
   dsw_pkg::divd_type   back_diff;

   always_comb begin
      unique case (divisor_ff)
         dsw_pkg::DIV_BY_100: begin
            recip = dsw_pkg::RECIP_100;
            shift = dsw_pkg::SHIFT_100;
         end
         dsw_pkg::DIV_BY_7: begin
            recip = dsw_pkg::RECIP_7;
            shift = dsw_pkg::SHIFT_7;
         end
         default: begin
            recip = '0;
            shift = '0;
         end
      endcase
   end

   // first pass: quotient by reciprocal, second pass: quotient times divisor
   always_comb begin
      if (phase_ff == P_BACK) begin
         mul_a = quot_ff;
         mul_b = dsw_pkg::recip_type'(divisor_ff);
      end else begin
         mul_a = num_ff;
         mul_b = recip;
      end
   end

   assign mul_p     = dsw_pkg::prod_type'(mul_a) * dsw_pkg::prod_type'(mul_b);
   assign back_diff = num_ff - mul_p[dsw_pkg::DIVD_W-1:0];

   always_comb begin
      phase_in   = phase_ff;
      done_in    = 1'b0;
      num_in     = num_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      unique case (phase_ff)
         P_IDLE: begin
            if (div_req.start) begin
               num_in     = div_req.dividend;
               divisor_in = div_req.divisor;
               phase_in   = P_RECIP;
            end
         end
         P_RECIP: begin
            quot_in  = dsw_pkg::divd_type'(mul_p >> shift);
            phase_in = P_BACK;
         end
         P_BACK: begin
            rem_in   = back_diff[dsw_pkg::DIVS_W-1:0];
            done_in  = 1'b1;
            phase_in = P_IDLE;
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

   `ASSERT_IMP(a_start_when_free, clock, reset, div_req.start, phase_ff == P_IDLE)
   `ASSERT_IMP(a_rem_below_divisor, clock, reset, done_ff, rem_ff < divisor_ff)
   `ASSERT_NXT(a_back_done, clock, reset, phase_ff == P_BACK, done_ff && phase_ff == P_IDLE)

endmodule

@@ rtl/dsw_date.sv @@
module dsw_date #(
   parameter int MAX_YEAR = dsw_pkg::MAX_YEAR_DEF
) (
   input  dsw_pkg::day_type       day,
   input  dsw_pkg::mon_type       month,
   input  dsw_pkg::year_type      year,
   input  dsw_pkg::q100_type      q100,
   input  dsw_pkg::divs_type      r100,
   input  dsw_pkg::dnum_type      prod,
   output dsw_pkg::date_info_type info
);

   localparam dsw_pkg::year_type MaxYearV = MAX_YEAR[dsw_pkg::YEAR_W-1:0];

   dsw_pkg::year_type p;
   logic              leap;
   dsw_pkg::day_type  len;
   dsw_pkg::divs_type k;
   dsw_pkg::q100_type j;
   dsw_pkg::zsum_type zsum;
   dsw_pkg::dnum_type daynum;
   dsw_pkg::dnum_type prod_next;
   logic              ok;

   always_comb begin
      p    = year - dsw_pkg::year_type'(1);
      leap = (year[1:0] == 2'b00) && ((r100 != dsw_pkg::R100_LAST) || (q100[1:0] == 2'b11));

      len = dsw_pkg::month_len(month);
      if (month == dsw_pkg::MON_FEB && leap) begin
         len = dsw_pkg::FEB_LEAP_LEN;
      end
      ok = (year != '0) && (year <= MaxYearV) &&
           (month >= dsw_pkg::MON_JAN) && (month <= dsw_pkg::MON_DEC) &&
           (day != '0) && (day <= len);

      // January and February belong to the previous year
      if (month < dsw_pkg::MON_MAR) begin
         k = r100;
         j = q100;
      end else if (r100 == dsw_pkg::R100_LAST) begin
         k = '0;
         j = q100 + dsw_pkg::q100_type'(1);
      end else begin
         k = r100 + dsw_pkg::divs_type'(1);
         j = q100;
      end
      zsum = dsw_pkg::zsum_type'(day) + dsw_pkg::zsum_type'(dsw_pkg::zeller_term(month)) +
             dsw_pkg::zsum_type'(k) + dsw_pkg::zsum_type'(k >> 2) +
             dsw_pkg::zsum_type'(j >> 2) + (dsw_pkg::zsum_type'(j) << 2) +
             dsw_pkg::zsum_type'(j);

      prod_next = dsw_pkg::dnum_type'(p) * dsw_pkg::dnum_type'(dsw_pkg::DAYS_PER_YEAR);

      daynum = prod + dsw_pkg::dnum_type'(p >> 2) - dsw_pkg::dnum_type'(q100) +
               dsw_pkg::dnum_type'(q100 >> 2) +
               dsw_pkg::dnum_type'(dsw_pkg::month_start(month)) +
               dsw_pkg::dnum_type'(day) +
               dsw_pkg::dnum_type'((month > dsw_pkg::MON_FEB) && leap);
   end

   assign info.ok     = ok;
   assign info.zsum   = zsum;
   assign info.p      = p;
   assign info.prod   = prod_next;
   assign info.daynum = daynum;

endmodule

@@ rtl/date_span_and_weekday.sv @@
// Requests are accepted only while idle, so a new item is not taken before the last
// result is written to the output register; that write waits while a result is stalled.
// Each date takes two divisions on the shared reciprocal divider, year - 1 by 100
// and then the weekday sum by 7.
// Reset (synchronous, active high) clears the sequencer and the result valid.
`include "assert_macros.svh"

module date_span_and_weekday #(
   parameter int MAX_YEAR = dsw_pkg::MAX_YEAR_DEF
) (
   input logic      clock,
   input logic      reset,
   dsw_req_if.sink   req_chan,
   dsw_rsp_if.source rsp_chan
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOAD   = 3'd1;
   localparam logic [2:0] S_DIVY   = 3'd2;
   localparam logic [2:0] S_CALC   = 3'd3;
   localparam logic [2:0] S_DIVW   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic                   sel_ff, sel_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   valid_ff, valid_in;
   dsw_pkg::req_data_type  in_ff, in_in;
   dsw_pkg::q100_type      q_ff, q_in;
   dsw_pkg::divs_type      r_ff, r_in;
   dsw_pkg::dnum_type      prod_ff, prod_in;
   dsw_pkg::dnum_type      n1_ff, n1_in;
   dsw_pkg::dnum_type      n2_ff, n2_in;
   dsw_pkg::wday_type      wd1_ff, wd1_in;
   dsw_pkg::wday_type      wd2_ff, wd2_in;
   dsw_pkg::rsp_data_type  rsp_data_ff, rsp_data_in;

   dsw_pkg::day_type       cur_day;
   dsw_pkg::mon_type       cur_month;
   dsw_pkg::year_type      cur_year;
   dsw_pkg::date_info_type info;
   dsw_pkg::div_req_type   div_req;
   dsw_pkg::div_rsp_type   div_rsp;
   dsw_pkg::dnum_type      diff;
   dsw_pkg::span_type      span;
   logic                   req_accept;
   logic                   rsp_fields_zero;
   logic                   rsp_wday_ok;
   logic                   div_wait;

   assign cur_day   = sel_ff ? in_ff.second_day   : in_ff.first_day;
   assign cur_month = sel_ff ? in_ff.second_month : in_ff.first_month;
   assign cur_year  = sel_ff ? in_ff.second_year  : in_ff.first_year;

   dsw_date #(
      .MAX_YEAR (MAX_YEAR)
   ) u_date (
      .day   (cur_day),
      .month (cur_month),
      .year  (cur_year),
      .q100  (q_ff),
      .r100  (r_ff),
      .prod  (prod_ff),
      .info  (info)
   );

   assign div_req.start    = (state_ff == S_LOAD) || (state_ff == S_CALC);
   assign div_req.dividend = (state_ff == S_CALC) ? dsw_pkg::divd_type'(info.zsum) : info.p;
   assign div_req.divisor  = (state_ff == S_CALC) ? dsw_pkg::DIV_BY_7 : dsw_pkg::DIV_BY_100;

   dsw_divu u_divu (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      diff = (n2_ff > n1_ff) ? (n2_ff - n1_ff) : '0;
      span = (diff > dsw_pkg::SPAN_MAX) ? dsw_pkg::span_type'(dsw_pkg::SPAN_MAX)
                                        : diff[dsw_pkg::SPAN_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      valid_in     = valid_ff;
      in_in        = in_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      prod_in      = prod_ff;
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      wd1_in       = wd1_ff;
      wd2_in       = wd2_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               in_in    = req_chan.data;
               sel_in   = 1'b0;
               valid_in = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_DIVY;
         end
         S_DIVY: begin
            if (div_rsp.done) begin
               q_in     = div_rsp.quot[dsw_pkg::Q100_W-1:0];
               r_in     = div_rsp.rem;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            prod_in  = info.prod;
            valid_in = valid_ff && info.ok;
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (div_rsp.done) begin
               if (!sel_ff) begin
                  n1_in    = info.daynum;
                  wd1_in   = div_rsp.rem[dsw_pkg::WDAY_W-1:0];
                  sel_in   = 1'b1;
                  state_in = S_LOAD;
               end else begin
                  n2_in    = info.daynum;
                  wd2_in   = div_rsp.rem[dsw_pkg::WDAY_W-1:0];
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               if (valid_ff) begin
                  rsp_data_in.dates_valid    = 1'b1;
                  rsp_data_in.day_span       = span;
                  rsp_data_in.first_weekday  = wd1_ff;
                  rsp_data_in.second_weekday = wd2_ff;
               end else begin
                  rsp_data_in = '0;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      valid_ff    <= valid_in;
      in_ff       <= in_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      prod_ff     <= prod_in;
      n1_ff       <= n1_in;
      n2_ff       <= n2_in;
      wd1_ff      <= wd1_in;
      wd2_ff      <= wd2_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   assign rsp_fields_zero = (rsp_data_ff.day_span == '0) && (rsp_data_ff.first_weekday == '0) &&
                            (rsp_data_ff.second_weekday == '0);
   assign rsp_wday_ok     = (rsp_data_ff.first_weekday < 3'd7) &&
                            (rsp_data_ff.second_weekday < 3'd7);
   assign div_wait        = (state_ff == S_DIVY) || (state_ff == S_DIVW);

   `ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.dates_valid, rsp_fields_zero)
   `ASSERT_IMP(a_weekday_range, clock, reset, rsp_valid_ff, rsp_wday_ok)
   `ASSERT_IMP(a_done_expected, clock, reset, div_rsp.done, div_wait)
   `ASSERT_NXT(a_accept_loads, clock, reset, req_accept, state_ff == S_LOAD && !sel_ff)

endmodule
